### rtl/tsi_pkg.sv
// ----------------------------------------------------------------------------
// tsi_pkg: shared types and constants for the tabulated sample integrator
// Word layouts, controller/datapath command and status bundles, and widths.
// ----------------------------------------------------------------------------
package tsi_pkg;

    localparam int DEFAULT_MAX_POINTS = 65536;

    // Working width of the Simpson numerator, two's complement
    localparam int WIDE_W = 136;
    // Signed width of the narrow multiplier operand
    localparam int NARROW_W = 36;
    // Width of the Simpson denominator and the divider remainder
    localparam int DEN_W = 70;

    typedef enum logic [1:0] {
        MODE_LEFT    = 2'd0,
        MODE_RIGHT   = 2'd1,
        MODE_TRAP    = 2'd2,
        MODE_SIMPSON = 2'd3
    } mode_t;

    localparam mode_t RESET_MODE = MODE_TRAP;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_ODD       = 2'd1,
        STATUS_ZERO_STEP = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_START,
        ST_MUL,
        ST_DIVSTART,
        ST_DIV,
        ST_SHIFT,
        ST_END
    } state_t;

    // Multiplier jobs; the Simpson jobs run in declaration order
    typedef enum logic [3:0] {
        OP_RECT,
        OP_P_T0,
        OP_T0,
        OP_P_T1,
        OP_T1,
        OP_P_T2,
        OP_T2,
        OP_NUM_S,
        OP_DEN
    } op_t;

    typedef struct packed {
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
        logic               last_point;
    } in_word_t;

    typedef struct packed {
        logic signed [63:0] integral;
        logic [1:0]         status;
    } out_word_t;

    typedef struct packed {
        logic  load;
        logic  mul_start;
        logic  mul_capture;
        logic  div_start;
        logic  div_capture;
        logic  set_zero_err;
        logic  shift;
        logic  emit;
        op_t   op;
    } cmd_t;

    typedef struct packed {
        logic  take;
        logic  has_prev;
        mode_t mode;
        logic  pair;
        logic  zero_step;
        logic  mul_done;
        logic  div_done;
        logic  last;
        logic  out_free;
    } sts_t;

endpackage

### rtl/tabulated_sample_integrator.sv
// ----------------------------------------------------------------------------
// tabulated_sample_integrator: streaming integral of a tabulated function
// Left, right, trapezoid or non-uniform Simpson rule over (x, y) points.
// ----------------------------------------------------------------------------
// One point is taken at a time. A rectangle or trapezoid step runs one
// shift-add multiply. A Simpson pair point runs eight multiplies and a
// 136-step restoring divide. The point marked last issues one word with
// the Q32.32 integral and a status. A result word waiting on the output
// holds only the next table's last point.
module tabulated_sample_integrator
    import tsi_pkg::*;
#(
    parameter int MAX_POINTS = DEFAULT_MAX_POINTS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_word_t   in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_word_t  out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    tsi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    tsi_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

### rtl/tsi_mul.sv
// ----------------------------------------------------------------------------
// tsi_mul: shift-add multiplier
// Signed wide-by-narrow product, one multiplier bit per cycle on magnitudes.
// ----------------------------------------------------------------------------
module tsi_mul
    import tsi_pkg::*;
#(
    parameter int AW = WIDE_W,
    parameter int BW = NARROW_W
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output logic                 done,
    output logic signed [AW-1:0] prod
);

    logic [AW-1:0] a_reg;
    logic [BW-1:0] b_reg;
    logic [AW-1:0] acc_reg;
    logic          neg_reg;
    logic          busy_reg;

    assign done = busy_reg && (b_reg == '0);
    assign prod = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a[AW-1] ? AW'(-a) : AW'(a);
            b_reg   <= b[BW-1] ? BW'(-b) : BW'(b);
            acc_reg <= '0;
            neg_reg <= a[AW-1] ^ b[BW-1];
        end
        else if (busy_reg && (b_reg != '0))
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[AW-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[BW-1:1]};
        end
    end

endmodule

### rtl/tsi_div.sv
// ----------------------------------------------------------------------------
// tsi_div: restoring divider
// Unsigned quotient of magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsi_div
    import tsi_pkg::*;
#(
    parameter int NW = WIDE_W,
    parameter int DW = DEN_W
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num_mag,
    input  logic [DW-1:0] den_mag,
    output logic          done,
    output logic [NW-1:0] quo
);

    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    q_reg;
    logic [DW-1:0]    r_reg;
    logic [DW-1:0]    d_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DW-1:0]    r_shift;
    logic             fits;

    assign r_shift = {r_reg[DW-2:0], q_reg[NW-1]};
    assign fits    = (r_shift >= d_reg);
    assign done    = busy_reg && (cnt_reg == '0);
    assign quo     = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NW);
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num_mag;
            r_reg <= '0;
            d_reg <= den_mag;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            r_reg <= fits ? (r_shift - d_reg) : r_shift;
            q_reg <= {q_reg[NW-2:0], fits};
        end
    end

endmodule

### rtl/tsi_dp.sv
// ----------------------------------------------------------------------------
// tsi_dp: integrator datapath
// Table state, step terms, shared multiplier, divider, output register.
// ----------------------------------------------------------------------------
module tsi_dp
    import tsi_pkg::*;
#(
    parameter int MAX_POINTS = DEFAULT_MAX_POINTS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output sts_t       sts,
    input  in_word_t   in_data,
    input  logic       cfg_wr,
    input  logic [1:0] cfg_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_word_t  out_data
);

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic signed [63:0] SUM_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] SUM_MIN = {1'b1, {63{1'b0}}};

    logic signed [31:0] x_in_reg, y_in_reg;
    logic               last_in_reg;
    mode_t              mode_reg;
    logic [CW-1:0]      count_reg;
    logic signed [31:0] prev_x_reg, prev_y_reg, prev2_x_reg, prev2_y_reg;
    logic signed [63:0] sum_reg;
    logic [1:0]         err_reg;
    logic signed [WIDE_W-1:0] p_reg, num_reg;
    logic signed [DEN_W-1:0]  den_reg;
    logic               div_neg_reg;
    logic               out_valid_reg;
    out_word_t          out_reg;

    logic signed [32:0] h_s, h1_s, ysum_s;
    logic signed [33:0] s_s;
    logic signed [34:0] d0_s, d2_s;
    logic signed [WIDE_W-1:0]   mul_a, mul_prod;
    logic signed [NARROW_W-1:0] mul_b;
    logic               mul_done, div_done;
    logic [WIDE_W-1:0]  div_num, div_quo;
    logic [DEN_W-1:0]   div_den;
    logic signed [DEN_W-1:0] den6;
    logic signed [63:0] final_value;
    status_t            final_status;

    function automatic logic signed [63:0] sat_wide(input logic signed [WIDE_W-1:0] v);
        logic [WIDE_W-64:0] hi;
        hi = v[WIDE_W-1:63];
        if ((&hi) || (~|hi))
            return v[63:0];
        return v[WIDE_W-1] ? SUM_MIN : SUM_MAX;
    endfunction

    function automatic logic signed [63:0] sat_mag(input logic neg,
                                                   input logic [WIDE_W-1:0] q);
        logic [63:0] m;
        m = q[63:0];
        if (|q[WIDE_W-1:64])
            return neg ? SUM_MIN : SUM_MAX;
        if (!neg)
            return m[63] ? SUM_MAX : $signed(m);
        if (m[63] && (|m[62:0]))
            return SUM_MIN;
        return -$signed(m);
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? SUM_MIN : SUM_MAX;
        return s[63:0];
    endfunction

    // Step terms
    assign h_s  = {x_in_reg[31], x_in_reg} - {prev_x_reg[31], prev_x_reg};
    assign h1_s = {prev_x_reg[31], prev_x_reg} - {prev2_x_reg[31], prev2_x_reg};
    assign s_s  = {h1_s[32], h1_s} + {h_s[32], h_s};
    assign d0_s = {h1_s[32], h1_s, 1'b0} - {{2{h_s[32]}}, h_s};
    assign d2_s = {h_s[32], h_s, 1'b0} - {{2{h1_s[32]}}, h1_s};

    always_comb
    begin
        case (mode_reg)
            MODE_LEFT:  ysum_s = {prev_y_reg[31], prev_y_reg};
            MODE_RIGHT: ysum_s = {y_in_reg[31], y_in_reg};
            default:    ysum_s = {prev_y_reg[31], prev_y_reg} + {y_in_reg[31], y_in_reg};
        endcase
    end

    always_comb
    begin
        case (cmd.op)
            OP_RECT:
            begin
                mul_a = {{(WIDE_W-33){h_s[32]}}, h_s};
                mul_b = {{(NARROW_W-33){ysum_s[32]}}, ysum_s};
            end
            OP_P_T0:
            begin
                mul_a = {{(WIDE_W-33){h_s[32]}}, h_s};
                mul_b = {{(NARROW_W-35){d0_s[34]}}, d0_s};
            end
            OP_T0:
            begin
                mul_a = p_reg;
                mul_b = {{(NARROW_W-32){prev2_y_reg[31]}}, prev2_y_reg};
            end
            OP_P_T1:
            begin
                mul_a = {{(WIDE_W-34){s_s[33]}}, s_s};
                mul_b = {{(NARROW_W-34){s_s[33]}}, s_s};
            end
            OP_T1:
            begin
                mul_a = p_reg;
                mul_b = {{(NARROW_W-32){prev_y_reg[31]}}, prev_y_reg};
            end
            OP_P_T2:
            begin
                mul_a = {{(WIDE_W-33){h1_s[32]}}, h1_s};
                mul_b = {{(NARROW_W-35){d2_s[34]}}, d2_s};
            end
            OP_T2:
            begin
                mul_a = p_reg;
                mul_b = {{(NARROW_W-32){y_in_reg[31]}}, y_in_reg};
            end
            OP_NUM_S:
            begin
                mul_a = num_reg;
                mul_b = {{(NARROW_W-34){s_s[33]}}, s_s};
            end
            OP_DEN:
            begin
                mul_a = {{(WIDE_W-33){h1_s[32]}}, h1_s};
                mul_b = {{(NARROW_W-33){h_s[32]}}, h_s};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    tsi_mul #(.AW(WIDE_W), .BW(NARROW_W)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    assign div_num = num_reg[WIDE_W-1] ? WIDE_W'(-num_reg) : WIDE_W'(num_reg);
    assign div_den = den_reg[DEN_W-1] ? DEN_W'(-den_reg) : DEN_W'(den_reg);

    tsi_div #(.NW(WIDE_W), .DW(DEN_W)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .num_mag (div_num),
        .den_mag (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // 6*h1*h2 as (4 + 2) times the product
    assign den6 = (mul_prod[DEN_W-1:0] <<< 2) + (mul_prod[DEN_W-1:0] <<< 1);

    // Final word
    always_comb
    begin
        final_value  = '0;
        final_status = STATUS_OK;
        if ((mode_reg == MODE_SIMPSON) && (count_reg != '0) && !count_reg[0])
        begin
            final_status = STATUS_ODD;
        end
        else if (err_reg != 2'd0)
        begin
            final_status = status_t'(err_reg);
        end
        else
        begin
            final_value = (mode_reg == MODE_TRAP) ? (sum_reg >>> 1) : sum_reg;
        end
    end

    always_comb
    begin
        sts.take      = (count_reg < CW'(MAX_POINTS));
        sts.has_prev  = (count_reg != '0);
        sts.mode      = mode_reg;
        sts.pair      = !count_reg[0];
        sts.zero_step = (h1_s == '0) || (h_s == '0);
        sts.mul_done  = mul_done;
        sts.div_done  = div_done;
        sts.last      = last_in_reg;
        sts.out_free  = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= RESET_MODE;
        end
        else if (cfg_wr)
        begin
            mode_reg <= mode_t'(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev2_x_reg   <= '0;
            prev2_y_reg   <= '0;
            sum_reg       <= '0;
            err_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.mul_capture && (cmd.op == OP_RECT))
            begin
                sum_reg <= sat_add(sum_reg, sat_wide(mul_prod));
            end
            if (cmd.div_capture)
            begin
                sum_reg <= sat_add(sum_reg, sat_mag(div_neg_reg, div_quo));
            end
            if (cmd.set_zero_err && (err_reg == 2'd0))
            begin
                err_reg <= STATUS_ZERO_STEP;
            end
            if (cmd.shift)
            begin
                prev2_x_reg <= prev_x_reg;
                prev2_y_reg <= prev_y_reg;
                prev_x_reg  <= x_in_reg;
                prev_y_reg  <= y_in_reg;
                count_reg   <= count_reg + 1'b1;
            end
            if (cmd.emit)
            begin
                count_reg     <= '0;
                prev_x_reg    <= '0;
                prev_y_reg    <= '0;
                prev2_x_reg   <= '0;
                prev2_y_reg   <= '0;
                sum_reg       <= '0;
                err_reg       <= 2'd0;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_in_reg    <= in_data.x_value;
            y_in_reg    <= in_data.y_value;
            last_in_reg <= in_data.last_point;
        end
        if (cmd.mul_capture)
        begin
            case (cmd.op)
                OP_P_T0, OP_P_T1, OP_P_T2: p_reg <= mul_prod;
                OP_T0, OP_NUM_S:           num_reg <= mul_prod;
                OP_T1, OP_T2:              num_reg <= num_reg + mul_prod;
                OP_DEN:                    den_reg <= den6;
                default:                   p_reg <= p_reg;
            endcase
        end
        if (cmd.div_start)
        begin
            div_neg_reg <= num_reg[WIDE_W-1] ^ den_reg[DEN_W-1];
        end
        if (cmd.emit)
        begin
            out_reg.integral <= final_value;
            out_reg.status   <= final_status;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count beyond table limit");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (count_reg == '0) && (sum_reg == '0) && (err_reg == 2'd0))
        else $error("table state not cleared after result");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg == 2'd0) || (err_reg == 2'd2))
        else $error("unexpected error code");

    a_units_apart: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_done && div_done))
        else $error("multiplier and divider finished together");
`endif

endmodule

### rtl/tsi_ctrl.sv
// ----------------------------------------------------------------------------
// tsi_ctrl: integrator controller
// Sequences one point through multiplies, divide, table update and result.
// ----------------------------------------------------------------------------
module tsi_ctrl
    import tsi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_RECT;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (!sts.take)
                    state_next = ST_END;
                else if (!sts.has_prev)
                    state_next = ST_SHIFT;
                else if (sts.mode != MODE_SIMPSON)
                begin
                    op_next    = OP_RECT;
                    state_next = ST_START;
                end
                else if (!sts.pair || sts.zero_step)
                    state_next = ST_SHIFT;
                else
                begin
                    op_next    = OP_P_T0;
                    state_next = ST_START;
                end
            end
            ST_START:
                state_next = ST_MUL;
            ST_MUL:
            begin
                if (sts.mul_done)
                begin
                    case (op_reg)
                        OP_RECT:  state_next = ST_SHIFT;
                        OP_DEN:   state_next = ST_DIVSTART;
                        OP_P_T0:  begin op_next = OP_T0;    state_next = ST_START; end
                        OP_T0:    begin op_next = OP_P_T1;  state_next = ST_START; end
                        OP_P_T1:  begin op_next = OP_T1;    state_next = ST_START; end
                        OP_T1:    begin op_next = OP_P_T2;  state_next = ST_START; end
                        OP_P_T2:  begin op_next = OP_T2;    state_next = ST_START; end
                        OP_T2:    begin op_next = OP_NUM_S; state_next = ST_START; end
                        OP_NUM_S: begin op_next = OP_DEN;   state_next = ST_START; end
                        default:  state_next = ST_SHIFT;
                    endcase
                end
            end
            ST_DIVSTART:
                state_next = ST_DIV;
            ST_DIV:
            begin
                if (sts.div_done)
                    state_next = ST_SHIFT;
            end
            ST_SHIFT:
                state_next = ST_END;
            ST_END:
            begin
                if (!sts.last || sts.out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall         = (state_reg != ST_IDLE);
        cmd              = '0;
        cmd.op           = op_reg;
        cmd.load         = (state_reg == ST_IDLE) && in_valid;
        cmd.mul_start    = (state_reg == ST_START);
        cmd.mul_capture  = (state_reg == ST_MUL) && sts.mul_done;
        cmd.div_start    = (state_reg == ST_DIVSTART);
        cmd.div_capture  = (state_reg == ST_DIV) && sts.div_done;
        cmd.set_zero_err = (state_reg == ST_EVAL) && sts.take && sts.has_prev
                           && (sts.mode == MODE_SIMPSON) && sts.pair && sts.zero_step;
        cmd.shift        = (state_reg == ST_SHIFT);
        cmd.emit         = (state_reg == ST_END) && sts.last && sts.out_free;
    end

`ifndef ASSERT_OFF
    a_div_after_den: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVSTART) |-> $past(op_reg) == OP_DEN)
        else $error("divide started before denominator was ready");

    a_emit_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.last && sts.out_free)
        else $error("result issued without a free output slot");

    a_one_unit_start: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.mul_start && cmd.div_start))
        else $error("two units started together");
`endif

endmodule
